@@ src/msb_first_bit_packer_top_defines.svh @@
`ifndef MSB_FIRST_BIT_PACKER_TOP_DEFINES_SVH
`define MSB_FIRST_BIT_PACKER_TOP_DEFINES_SVH

// Checks that a condition implies another in the current cycle.
`define MSBP_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("packer check failed");

// Checks that a condition implies another in the following cycle.
`define MSBP_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("packer check failed");

`endif

@@ src/msbp_pkg.sv @@
package msbp_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int FIELD_W         = 32;
    localparam int CAP_W           = 16;
    localparam logic [CAP_W-1:0] CAP_RESET = 16'hFFFF;

    typedef enum logic [0:0] {
        OP_WRITE = 1'b0,
        OP_ALIGN = 1'b1
    } opcode_t;

    // One queued job: up to four whole bytes, first byte in the top bits.
    typedef struct packed {
        logic [FIELD_W-1:0] data;
        logic [2:0]         nbytes;
    } job_t;

    // Front status seen by the top level.
    typedef struct packed {
        logic       push;
        logic [2:0] pend_count;
    } front_status_t;

endpackage

@@ src/msb_first_bit_packer_top.sv @@
// MSB-first bit packer. Write words append up to 32 bits to a running bit
// string and each byte that fills up leaves on the result channel, earliest bit
// in the top position; align words flush the partial byte padded with zeros.
// An input word is taken in every cycle while the two-entry job queue has room;
// a write word yields up to four bytes and the result port carries one byte a
// cycle while out_stall is low. With the queue empty and the result port free,
// the first byte of a word is written into the job queue and then into the
// output register before it appears. Bytes beyond capacity_bytes are replaced
// by zero and flagged as overflow; capacity_bytes may only be written while
// the packer is idle.
module msb_first_bit_packer_top #(
    parameter int COUNT_WIDTH = msbp_pkg::COUNT_WIDTH_DEF,
    parameter int QUEUE_DEPTH = msbp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [msbp_pkg::CAP_W-1:0] capacity_bytes,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       opcode,
    input  logic [31:0]                field_value,
    input  logic [5:0]                 bit_count,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [7:0]                 out_byte,
    output logic                       overflow,
    output logic                       last
);
    import msbp_pkg::*;

    `include "msb_first_bit_packer_top_defines.svh"

    logic [CAP_W-1:0] capacity_reg;
    job_t             push_job;
    job_t             head;
    front_status_t    front_status;
    logic             q_empty;
    logic             q_full;
    logic             pop;
    logic             in_accept;
    logic             align_flush;

    assign cfg_ready   = 1'b1;
    assign in_accept   = in_valid && !in_stall;
    assign align_flush = in_accept && (opcode == OP_ALIGN) && (front_status.pend_count != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            capacity_reg <= capacity_bytes;
        end
    end

    msbp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .field_value (field_value),
        .bit_count   (bit_count),
        .q_full      (q_full),
        .push_job    (push_job),
        .status      (front_status)
    );

    msbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (front_status.push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    msbp_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .capacity  (capacity_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .overflow  (overflow),
        .last      (last)
    );

    `MSBP_ASSERT_NOW(a_drop_is_zero, out_valid && overflow, out_byte == 8'd0)
    `MSBP_ASSERT_NEXT(a_align_queues, align_flush, !q_empty)
    `MSBP_ASSERT_NEXT(a_word_continues, out_valid && !out_stall && !last, out_valid)

endmodule

@@ src/msbp_front.sv @@
module msbp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 opcode,
    input  logic [31:0]          field_value,
    input  logic [5:0]           bit_count,
    input  logic                 q_full,
    output msbp_pkg::job_t        push_job,
    output msbp_pkg::front_status_t status
);
    import msbp_pkg::*;

    logic [6:0]  pend_bits_reg;
    logic [6:0]  pend_bits_next;
    logic [2:0]  pend_cnt_reg;
    logic [2:0]  pend_cnt_next;
    logic        accept;
    logic [5:0]  n_bits;
    logic [32:0] ones_shift;
    logic [31:0] value_masked;
    logic [38:0] acc;
    logic [5:0]  cnt;
    logic [39:0] aligned;
    logic [6:0]  keep_mask;
    logic [7:0]  flush_byte;
    logic        push;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        n_bits       = (bit_count > 6'd32) ? 6'd32 : bit_count;
        ones_shift   = {33{1'b1}} << n_bits;
        value_masked = field_value & ~ones_shift[31:0];
        acc          = ({32'd0, pend_bits_reg} << n_bits) | {7'd0, value_masked};
        cnt          = {3'd0, pend_cnt_reg} + n_bits;
        // Place the oldest whole byte at the top of a 40-bit word.
        aligned      = {1'b0, acc} << (6'd40 - cnt);
        keep_mask    = ~(7'h7F << cnt[2:0]);
        flush_byte   = {1'b0, pend_bits_reg} << (4'd8 - {1'b0, pend_cnt_reg});
    end

    always_comb
    begin
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        push           = 1'b0;
        push_job.data  = aligned[39:8];
        push_job.nbytes = cnt[5:3];
        if (accept)
        begin
            unique case (opcode_t'(opcode))
                OP_ALIGN:
                begin
                    push_job.data   = {flush_byte, 24'd0};
                    push_job.nbytes = 3'd1;
                    if (pend_cnt_reg != 3'd0)
                    begin
                        push           = 1'b1;
                        pend_bits_next = 7'd0;
                        pend_cnt_next  = 3'd0;
                    end
                end
                OP_WRITE:
                begin
                    push           = (cnt[5:3] != 3'd0);
                    pend_cnt_next  = cnt[2:0];
                    pend_bits_next = acc[6:0] & keep_mask;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    assign status.push       = push;
    assign status.pend_count = pend_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_bits_reg <= 7'd0;
            pend_cnt_reg  <= 3'd0;
        end
        else
        begin
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
        end
    end

endmodule

@@ src/msbp_queue.sv @@
module msbp_queue #(
    parameter int DEPTH = msbp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  msbp_pkg::job_t push_job,
    input  logic           pop,
    output msbp_pkg::job_t head,
    output logic           empty,
    output logic           full
);
    import msbp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_FULL);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ src/msbp_back.sv @@
module msbp_back #(
    parameter int COUNT_WIDTH = msbp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  msbp_pkg::job_t               head,
    input  logic                         q_empty,
    output logic                         pop,
    input  logic [msbp_pkg::CAP_W-1:0]   capacity,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [7:0]                   out_byte,
    output logic                         overflow,
    output logic                         last
);
    import msbp_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > CAP_W) ? COUNT_WIDTH : CAP_W;

    logic [1:0]             idx_reg;
    logic [1:0]             idx_next;
    logic [COUNT_WIDTH-1:0] emitted_reg;
    logic [COUNT_WIDTH-1:0] emitted_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [7:0]             out_byte_reg;
    logic                   overflow_reg;
    logic                   last_reg;
    logic                   advance;
    logic                   take;
    logic                   is_last;
    logic                   buf_full;
    logic [31:0]            shifted;

    assign advance  = !out_valid_reg || !out_stall;
    assign take     = advance && !q_empty;
    assign shifted  = head.data << {idx_reg, 3'b000};
    assign is_last  = (({1'b0, idx_reg} + 3'd1) == head.nbytes);
    // Once the counter saturates every further byte is dropped as well.
    assign buf_full = (CMP_W'(emitted_reg) >= CMP_W'(capacity)) || (&emitted_reg);
    assign pop      = take && is_last;

    always_comb
    begin
        idx_next       = idx_reg;
        emitted_next   = emitted_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = !q_empty;
        end
        if (take)
        begin
            idx_next = is_last ? 2'd0 : idx_reg + 2'd1;
            if (!buf_full)
            begin
                emitted_next = emitted_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            emitted_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            emitted_reg   <= emitted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_byte_reg <= buf_full ? 8'd0 : shifted[31:24];
            overflow_reg <= buf_full;
            last_reg     <= is_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign overflow  = overflow_reg;
    assign last      = last_reg;

endmodule

@@ test/tb_msb_first_bit_packer_top.sv @@
`timescale 1ns / 100ps

module tb_msb_first_bit_packer_top;

    import msbp_pkg::*;

    localparam int RESET_CYCLES = 12;
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [7:0] data;
        logic       ovf;
        logic       lst;
    } byte_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CAP_W-1:0]  capacity_bytes = CAP_RESET;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              opcode = OP_WRITE;
    logic [31:0]       field_value = '0;
    logic [5:0]        bit_count = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [7:0]        out_byte;
    logic              overflow;
    logic              last;

    // Predicted packer state and the bytes still awaited on the output.
    logic [6:0]        pend_bits = '0;
    logic [2:0]        pend_cnt = '0;
    logic [15:0]       bytes_out = '0;
    logic [CAP_W-1:0]  cap_limit = CAP_RESET;
    byte_result_t      expected_bytes[$];

    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                error_count = 0;
    int                quiet_cycles = 0;

    msb_first_bit_packer_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .capacity_bytes (capacity_bytes),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .field_value    (field_value),
        .bit_count      (bit_count),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .overflow       (overflow),
        .last           (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Accounts one byte against the capacity; a dropped byte reads as zero.
    function automatic byte_result_t take_byte(logic [7:0] b);
        byte_result_t r;
        r.ovf = (bytes_out >= cap_limit) || (bytes_out == '1);
        r.data = r.ovf ? 8'h00 : b;
        r.lst = 1'b0;
        if (!r.ovf)
            bytes_out++;
        return r;
    endfunction

    // Returns 0 for a word that leaves the packer untouched.
    function automatic bit pack_predict(opcode_t op, logic [31:0] val, logic [5:0] cnt);
        byte_result_t burst[$];
        logic [63:0]  acc;
        int           n;
        int           left;
        if (op == OP_ALIGN)
        begin
            if (pend_cnt == 0)
                return 1'b0;
            acc = 64'(pend_bits) << (8 - pend_cnt);
            burst.push_back(take_byte(acc[7:0]));
            pend_bits = '0;
            pend_cnt = '0;
        end
        else
        begin
            n = (cnt > 32) ? 32 : int'(cnt);
            if (n == 0)
                return 1'b0;
            acc = (64'(pend_bits) << n) | (64'(val) & ((64'd1 << n) - 64'd1));
            left = int'(pend_cnt) + n;
            while (left >= 8)
            begin
                burst.push_back(take_byte(8'(acc >> (left - 8))));
                left -= 8;
            end
            pend_cnt = 3'(left);
            pend_bits = 7'(acc & ((64'd1 << left) - 64'd1));
        end
        if (burst.size() > 0)
            burst[burst.size() - 1].lst = 1'b1;
        foreach (burst[i])
            expected_bytes.push_back(burst[i]);
        return 1'b1;
    endfunction

    task automatic send_word(opcode_t op, logic [31:0] val, logic [5:0] cnt, output bit useful);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        field_value <= val;
        bit_count <= cnt;
        do
            @(posedge clk);
        while (in_stall);
        useful = pack_predict(op, val, cnt);
    endtask

    task automatic send(opcode_t op, logic [31:0] val, logic [5:0] cnt);
        bit useful;
        send_word(op, val, cnt, useful);
    endtask

    // The packer may still hold a word that yields no byte, hence the settling pause.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        wait_idle();
        cfg_valid <= 1'b1;
        capacity_bytes <= cap;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cap_limit = cap;
    endtask

    task automatic test_directed();
        send(OP_ALIGN, 32'h0000_0000, 6'd0);
        send(OP_WRITE, 32'hFFFF_FFFF, 6'd1);
        send(OP_WRITE, 32'hFFFF_FFFF, 6'd32);
        send(OP_WRITE, 32'h0000_0000, 6'd32);
        send(OP_WRITE, 32'h0000_005A, 6'd6);
        send(OP_WRITE, 32'hA5A5_A5A5, 6'd32);
        send(OP_ALIGN, 32'hFFFF_FFFF, 6'd63);
        send(OP_ALIGN, 32'h0000_0000, 6'd8);
        send(OP_WRITE, 32'hDEAD_BEEF, 6'd0);
        send(OP_WRITE, 32'h1234_5678, 6'd63);
        send(OP_WRITE, 32'h8765_4321, 6'd33);
        send(OP_WRITE, 32'h0000_0003, 6'd2);
        send(OP_WRITE, 32'hFFFF_FFF8, 6'd3);
        send(OP_ALIGN, 32'h0000_0000, 6'd0);
        send(OP_WRITE, 32'h8000_0000, 6'd32);
        send(OP_WRITE, 32'hFFFF_FF01, 6'd8);
        send(OP_WRITE, 32'h0000_007F, 6'd7);
        send(OP_ALIGN, 32'h0000_0000, 6'd0);
    endtask

    // With no room at all every byte must come back zeroed and flagged.
    task automatic test_capacity_extremes();
        write_capacity('0);
        send(OP_WRITE, 32'hFFFF_FFFF, 6'd32);
        send(OP_WRITE, 32'h0000_0015, 6'd5);
        send(OP_ALIGN, 32'h0000_0000, 6'd0);
        write_capacity(16'd1);
        send(OP_WRITE, 32'h0000_ABCD, 6'd16);
        send(OP_WRITE, 32'h0000_0001, 6'd1);
        send(OP_ALIGN, 32'h0000_0000, 6'd0);
    endtask

    task automatic test_random_traffic(int idle_pct, int stall_pct, int headroom, int n_words);
        int          done;
        int          roll;
        opcode_t     op;
        logic [5:0]  cnt;
        bit          useful;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        write_capacity((int'(bytes_out) + headroom > 65535) ? CAP_RESET
                                                           : CAP_W'(int'(bytes_out) + headroom));
        done = 0;
        while (done < n_words)
        begin
            roll = $urandom_range(99);
            op = (roll < 10) ? OP_ALIGN : OP_WRITE;
            if (roll < 10 || roll >= 15)
                cnt = $urandom_range(1) ? 6'($urandom_range(1, 8)) : 6'($urandom_range(1, 32));
            else
                cnt = $urandom_range(1) ? 6'd0 : 6'($urandom_range(33, 63));
            send_word(op, $urandom, cnt, useful);
            if (useful)
                done++;
        end
    endtask

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        byte_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bytes.size() == 0)
                report_mismatch($sformatf("unexpected byte %02h", out_byte));
            else
            begin
                want = expected_bytes.pop_front();
                if (out_byte !== want.data)
                    report_mismatch($sformatf("out_byte %02h, wanted %02h", out_byte, want.data));
                if (overflow !== want.ovf)
                    report_mismatch($sformatf("overflow %b, wanted %b", overflow, want.ovf));
                if (last !== want.lst)
                    report_mismatch($sformatf("last %b, wanted %b", last, want.lst));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[msb_first_bit_packer_top] ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 20;
        recv_stall_pct = 70;
        test_directed();
        test_capacity_extremes();
        test_random_traffic(20, 70, $urandom_range(60, 200), 130);
        test_random_traffic(70, 20, $urandom_range(60, 200), 130);
        test_random_traffic(0, 0, 65535, 140);
        wait_idle();
        if (error_count == 0)
            $display("[msb_first_bit_packer_top] OK");
        else
            $display("[msb_first_bit_packer_top] ERROR");
        $finish;
    end

endmodule
